[design/sbs_pkg.sv]
// Package for the sharp bilinear 4x RGB565 scaler: sizes, weights, gamma tables, command struct.
`default_nettype none
package sbs_pkg;

    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;
    localparam int SCALE      = 4;

    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int BANK_AW    = COL_W + ROW_W - 2;
    localparam int BANK_DEPTH = (MAX_WIDTH / 2) * (MAX_HEIGHT / 2);

    localparam logic [0:0] CFG_SRC_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_SRC_HEIGHT = 1'b1;

    localparam logic MODE_WRITE   = 1'b0;
    localparam logic MODE_COMPUTE = 1'b1;

    typedef logic [10:0] weight_t [SCALE];
    localparam weight_t WEIGHT = '{11'd22, 11'd306, 11'd718, 11'd1002};

    typedef logic [7:0] enc5_t [32];
    typedef logic [7:0] enc6_t [64];
    typedef logic [7:0] dec_t  [256];

    function automatic enc5_t gen_enc5();
        enc5_t t;
        for (int i = 0; i < 32; i++)
        begin
            t[i] = 8'($rtoi(255.0 * $pow(real'(8 * i) / 255.0, 1.6) + 0.5));
        end
        return t;
    endfunction

    function automatic enc6_t gen_enc6();
        enc6_t t;
        for (int i = 0; i < 64; i++)
        begin
            t[i] = 8'($rtoi(255.0 * $pow(real'(4 * i) / 255.0, 1.6) + 0.5));
        end
        return t;
    endfunction

    function automatic dec_t gen_dec();
        dec_t t;
        for (int i = 0; i < 256; i++)
        begin
            t[i] = 8'($rtoi(255.0 * $pow(real'(i) / 255.0, 0.625) + 0.5));
        end
        return t;
    endfunction

    localparam enc5_t ENC5 = gen_enc5();
    localparam enc6_t ENC6 = gen_enc6();
    localparam dec_t  DEC  = gen_dec();

    typedef struct packed {
        logic wr;
        logic map;
        logic rd;
        logic enc;
        logic hbl;
        logic vbl;
        logic pack;
    } sbs_cmd_t;

endpackage
`default_nettype wire

[design/sharp_bilinear_4x_rgb565_scaler_unit.sv]
// Sharp bilinear 4x RGB565 scaler: top level joining controller and datapath.
// Write beat: stored when accepted, next beat can follow in the next cycle.
// Compute beat: steps map, read, encode, blend, pack; next beat accepted once result is taken.
// One compute beat at a time: the step sequencer takes no new beat until the result is taken.
// Reset: asynchronous, clears control and size registers (256 x 224); frame store is not cleared.
`default_nettype none
module sharp_bilinear_4x_rgb565_scaler_unit
    import sbs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [0:0]        cfg_index,
    input  wire logic [9:0]        cfg_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              mode,
    input  wire logic [COL_W-1:0]  src_col,
    input  wire logic [ROW_W-1:0]  src_row,
    input  wire logic [15:0]       src_pixel,
    input  wire logic [10:0]       dst_col,
    input  wire logic [10:0]       dst_row,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [15:0]            dst_pixel
);

    sbs_cmd_t cmd;

    sbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .mode      (mode),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    sbs_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .src_col   (src_col),
        .src_row   (src_row),
        .src_pixel (src_pixel),
        .dst_col   (dst_col),
        .dst_row   (dst_row),
        .dst_pixel (dst_pixel)
    );

endmodule
`default_nettype wire

[design/sbs_ctrl.sv]
// Controller: issues write beats and sequences one compute beat through map, read, encode, blend and pack steps.
`default_nettype none
module sbs_ctrl
    import sbs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire logic     mode,
    output logic          in_stall,
    output logic          out_valid,
    input  wire logic     out_stall,
    output sbs_cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_MAP, S_RD, S_ENC, S_HBL, S_VBL, S_PACK, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (mode == MODE_COMPUTE)
                    begin
                        cmd.map    = 1'b1;
                        state_next = S_MAP;
                    end
                    else
                    begin
                        cmd.wr = 1'b1;
                    end
                end
            end
            S_MAP:
            begin
                cmd.rd     = 1'b1;
                state_next = S_RD;
            end
            S_RD:
            begin
                cmd.enc    = 1'b1;
                state_next = S_ENC;
            end
            S_ENC:
            begin
                cmd.hbl    = 1'b1;
                state_next = S_HBL;
            end
            S_HBL:
            begin
                cmd.vbl    = 1'b1;
                state_next = S_VBL;
            end
            S_VBL:
            begin
                cmd.pack       = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_PACK;
            end
            S_PACK, S_OUT:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

[design/sbs_datapath.sv]
// Datapath: size registers, four parity-banked frame stores, gamma encode, blend, decode, repack.
`default_nettype none
module sbs_datapath
    import sbs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [0:0]        cfg_index,
    input  wire logic [9:0]        cfg_data,
    input  wire sbs_cmd_t          cmd,
    input  wire logic [COL_W-1:0]  src_col,
    input  wire logic [ROW_W-1:0]  src_row,
    input  wire logic [15:0]       src_pixel,
    input  wire logic [10:0]       dst_col,
    input  wire logic [10:0]       dst_row,
    output logic [15:0]            dst_pixel
);

    logic [9:0] width_reg, height_reg;
    logic [9:0] w_eff, h_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 10'd256;
            height_reg <= 10'd224;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SRC_WIDTH:  width_reg  <= cfg_data;
                CFG_SRC_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        priority if (width_reg < 10'd2)           w_eff = 10'd2;
        else if (width_reg > 10'(MAX_WIDTH))      w_eff = 10'(MAX_WIDTH);
        else                                      w_eff = width_reg;
        priority if (height_reg < 10'd2)          h_eff = 10'd2;
        else if (height_reg > 10'(MAX_HEIGHT))    h_eff = 10'(MAX_HEIGHT);
        else                                      h_eff = height_reg;
    end

    // coordinate map
    logic [10:0]      cx_m2, cy_m2;
    logic [COL_W-1:0] qx, limx;
    logic [ROW_W-1:0] qy, limy;
    logic [COL_W-1:0] sx_reg;
    logic [ROW_W-1:0] sy_reg;
    logic [1:0]       px_reg, py_reg;

    assign cx_m2 = dst_col - 11'd2;
    assign cy_m2 = dst_row - 11'd2;
    assign limx  = COL_W'(w_eff - 10'd2);
    assign limy  = ROW_W'(h_eff - 10'd2);

    always_comb
    begin
        logic [10:0] tx, ty;
        tx = (dst_col < 11'd2) ? 11'd0 : (cx_m2 >> 2);
        ty = (dst_row < 11'd2) ? 11'd0 : (cy_m2 >> 2);
        qx = (tx > 11'(limx)) ? limx : COL_W'(tx);
        qy = (ty > 11'(limy)) ? limy : ROW_W'(ty);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.map)
        begin
            sx_reg <= qx;
            sy_reg <= qy;
            px_reg <= cx_m2[1:0];
            py_reg <= cy_m2[1:0];
        end
    end

    // frame store, bank index {row[0], col[0]}
    logic [COL_W-1:0] sx1;
    logic [ROW_W-1:0] sy1;
    logic [15:0]      rdata_reg [4];

    assign sx1 = sx_reg + COL_W'(1);
    assign sy1 = sy_reg + ROW_W'(1);

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [15:0]      bank_mem [BANK_DEPTH];
        logic [COL_W-1:0] rc;
        logic [ROW_W-1:0] rr;
        logic [BANK_AW-1:0] raddr, waddr;
        logic             wsel;

        assign rc    = (sx_reg[0] == b[0]) ? sx_reg : sx1;
        assign rr    = (sy_reg[0] == b[1]) ? sy_reg : sy1;
        assign raddr = {rr[ROW_W-1:1], rc[COL_W-1:1]};
        assign waddr = {src_row[ROW_W-1:1], src_col[COL_W-1:1]};
        assign wsel  = cmd.wr && (src_col[0] == b[0]) && (src_row[0] == b[1]);

        always_ff @(posedge clk)
        begin
            if (wsel)
            begin
                bank_mem[waddr] <= src_pixel;
            end
            if (cmd.rd)
            begin
                rdata_reg[b] <= bank_mem[raddr];
            end
        end
    end

    // gamma encode; neighbor k: 0=(x,y) 1=(x+1,y) 2=(x,y+1) 3=(x+1,y+1)
    logic [7:0] enc_reg [4][3];

    always_ff @(posedge clk)
    begin
        if (cmd.enc)
        begin
            for (int k = 0; k < 4; k++)
            begin
                logic [1:0]  bi;
                logic [15:0] p;
                bi = {sy_reg[0] ^ k[1], sx_reg[0] ^ k[0]};
                p  = rdata_reg[bi];
                enc_reg[k][0] <= ENC5[p[15:11]];
                enc_reg[k][1] <= ENC6[p[10:5]];
                enc_reg[k][2] <= ENC5[p[4:0]];
            end
        end
    end

    // horizontal blend, Q8.10
    logic [10:0] wx, wxc, wy, wyc;
    logic [17:0] top_reg [3];
    logic [17:0] bot_reg [3];

    assign wx  = WEIGHT[px_reg];
    assign wxc = 11'd1024 - wx;
    assign wy  = WEIGHT[py_reg];
    assign wyc = 11'd1024 - wy;

    always_ff @(posedge clk)
    begin
        if (cmd.hbl)
        begin
            for (int c = 0; c < 3; c++)
            begin
                top_reg[c] <= 18'(enc_reg[0][c]) * 18'(wxc) + 18'(enc_reg[1][c]) * 18'(wx);
                bot_reg[c] <= 18'(enc_reg[2][c]) * 18'(wxc) + 18'(enc_reg[3][c]) * 18'(wx);
            end
        end
    end

    // vertical blend, round and saturate
    logic [7:0] v_reg [3];

    always_ff @(posedge clk)
    begin
        if (cmd.vbl)
        begin
            for (int c = 0; c < 3; c++)
            begin
                logic [28:0] s;
                logic [8:0]  r;
                s = 29'(top_reg[c]) * 29'(wyc) + 29'(bot_reg[c]) * 29'(wy) + 29'(1 << 19);
                r = s[28:20];
                v_reg[c] <= (r > 9'd255) ? 8'd255 : r[7:0];
            end
        end
    end

    // decode and repack
    logic [15:0] pix_reg;
    logic [7:0]  dr, dg, db;

    assign dr = DEC[v_reg[0]];
    assign dg = DEC[v_reg[1]];
    assign db = DEC[v_reg[2]];

    always_ff @(posedge clk)
    begin
        if (cmd.pack)
        begin
            pix_reg <= {dr[7:3], dg[7:2], db[7:3]};
        end
    end

    assign dst_pixel = pix_reg;

endmodule
`default_nettype wire

[design/sbs_checker.sv]
// Port-level checker for the scaler, bound to the top level.
`default_nettype none
module sbs_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        mode,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [15:0] dst_pixel
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(dst_pixel))
        else $error("result beat dropped or changed while stalled");

    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && mode |=> in_stall)
        else $error("input taken right after a compute beat");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while a result is pending");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !mode |=> !out_valid)
        else $error("result after a write beat");

endmodule

bind sharp_bilinear_4x_rgb565_scaler_unit sbs_checker u_sbs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dst_pixel (dst_pixel)
);
`default_nettype wire
